// ===== rtl/core/patlo_pkg.sv =====
// ----------------------------------------------------------------------------
// patlo_pkg
// Shared widths and constants for the parent-array level-order walker.
// ----------------------------------------------------------------------------
package patlo_pkg;

    localparam int PARENT_W       = 5;
    localparam int LABEL_W        = 8;
    localparam int START_W        = 5;
    localparam int DEF_MAX_NODES  = 32;
    localparam int RESULT_CAP     = 32;
    localparam int RESULT_CNT_W   = $clog2(RESULT_CAP);

endpackage
// ----------------------------------------------------------------------------

// ===== rtl/core/patlo_node_if.sv =====
// ----------------------------------------------------------------------------
// patlo_node_if
// Node load channel: one tree node per word.
// ----------------------------------------------------------------------------
interface patlo_node_if
    import patlo_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [PARENT_W-1:0] parent_index;
    logic [LABEL_W-1:0]  node_label;
    logic                last_node;

    modport source (output valid, parent_index, node_label, last_node, input ready);
    modport sink   (input valid, parent_index, node_label, last_node, output ready);
endinterface
// ----------------------------------------------------------------------------

// ===== rtl/core/patlo_visit_if.sv =====
// ----------------------------------------------------------------------------
// patlo_visit_if
// Visit channel: one visited label per word.
// ----------------------------------------------------------------------------
interface patlo_visit_if
    import patlo_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [LABEL_W-1:0] visit_label;
    logic               last_visit;

    modport source (output valid, visit_label, last_visit, input ready);
    modport sink   (input valid, visit_label, last_visit, output ready);
endinterface
// ----------------------------------------------------------------------------

// ===== rtl/core/parent_array_tree_level_order_top.sv =====
// ----------------------------------------------------------------------------
// parent_array_tree_level_order_top
// Loads a parent-array tree and emits its labels in breadth-first order.
//
// Usage:
//   in_node   : node words in index order (parent, label, last mark). One
//               word per cycle is taken while loading. Nodes past MAX_NODES
//               are dropped; the last mark still starts the walk.
//   out_visit : visited labels in level order, last_visit on the final one.
//   cfg_we / cfg_wdata : start_node register, written while idle.
// Throughput: loading runs at one node per cycle. The walk holds in_node
//   off. Each visited node passes queue pop, queue read, label read, a scan
//   of every index above it through the parent memory's single read port,
//   and emit. The start node skips the two queue steps.
// Stall: a label waits in the output register; the walk pauses at the next
//   emit until it is taken. Loading resumes while the final label waits.
// Reset: node count, queue pointers and start_node clear; the memories are
//   not cleared and only entries of the current load are read.
// ----------------------------------------------------------------------------
module parent_array_tree_level_order_top
    import patlo_pkg::*;
#(
    parameter int MAX_NODES = DEF_MAX_NODES
)(
    input  logic               clk,
    input  logic               rst_n,
    patlo_node_if.sink         in_node,
    patlo_visit_if.source      out_visit,
    input  logic               cfg_we,
    input  logic [START_W-1:0] cfg_wdata
);

    localparam int IDX_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int CNT_W = IDX_W + 1;
    localparam int CMP_W = (IDX_W > PARENT_W) ? IDX_W : PARENT_W;
    localparam int SC_W  = (CNT_W > START_W) ? CNT_W : START_W;

    typedef enum logic [2:0] {
        S_LOAD,
        S_POP,
        S_POPW,
        S_VISIT,
        S_SCAN,
        S_EMIT
    } state_t;

    state_t                  state_reg;
    logic [START_W-1:0]      start_reg;
    logic [CNT_W-1:0]        count_reg;
    logic [IDX_W-1:0]        head_reg;
    logic [IDX_W-1:0]        tail_reg;
    logic [CNT_W-1:0]        used_reg;
    logic [IDX_W-1:0]        cur_reg;
    logic [CNT_W-1:0]        scan_reg;
    logic                    pend_reg;
    logic [IDX_W-1:0]        pend_idx_reg;
    logic [RESULT_CNT_W-1:0] k_reg;
    logic                    out_valid_reg;
    logic [LABEL_W-1:0]      out_label_reg;
    logic                    out_last_reg;

    logic [PARENT_W-1:0]     parent_mem [MAX_NODES];
    logic [LABEL_W-1:0]      label_mem  [MAX_NODES];
    logic [IDX_W-1:0]        fifo_mem   [MAX_NODES];
    logic [PARENT_W-1:0]     parent_q;
    logic [LABEL_W-1:0]      label_q;
    logic [IDX_W-1:0]        fifo_q;

    logic                    in_go;
    logic                    store_en;
    logic [CNT_W-1:0]        count_new;
    logic                    start_ok;
    logic                    scan_issue;
    logic                    push;
    logic                    out_free;
    logic                    emit_go;
    logic                    emit_last;

    assign in_node.ready       = (state_reg == S_LOAD);
    assign in_go               = in_node.valid && in_node.ready;
    assign store_en            = in_go && (count_reg < CNT_W'(MAX_NODES));
    assign count_new           = count_reg + CNT_W'(store_en);
    assign start_ok            = SC_W'(start_reg) < SC_W'(count_new);
    assign scan_issue          = (state_reg == S_SCAN) && (scan_reg < count_reg);
    assign push                = (state_reg == S_SCAN) && pend_reg
                                 && (CMP_W'(parent_q) == CMP_W'(cur_reg));
    assign out_free            = !out_valid_reg || out_visit.ready;
    assign emit_go             = (state_reg == S_EMIT) && out_free;
    assign emit_last           = (used_reg == '0)
                                 || (k_reg == RESULT_CNT_W'(RESULT_CAP - 1));

    assign out_visit.valid       = out_valid_reg;
    assign out_visit.visit_label = out_label_reg;
    assign out_visit.last_visit  = out_last_reg;

    // tree stores
    always_ff @(posedge clk)
    begin
        if (store_en)
        begin
            parent_mem[count_reg[IDX_W-1:0]] <= (count_reg == '0) ? '0
                                                : in_node.parent_index;
            label_mem[count_reg[IDX_W-1:0]]  <= in_node.node_label;
        end
        if (scan_issue)
        begin
            parent_q <= parent_mem[scan_reg[IDX_W-1:0]];
        end
        if (state_reg == S_VISIT)
        begin
            label_q <= label_mem[cur_reg];
        end
    end

    // visit queue
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_mem[tail_reg] <= pend_idx_reg;
        end
        if (state_reg == S_POP)
        begin
            fifo_q <= fifo_mem[head_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            start_reg     <= '0;
            count_reg     <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            used_reg      <= '0;
            cur_reg       <= '0;
            scan_reg      <= '0;
            pend_reg      <= 1'b0;
            pend_idx_reg  <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
            out_label_reg <= '0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                start_reg <= cfg_wdata;
            end
            if (emit_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_visit.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_LOAD:
                begin
                    if (in_go)
                    begin
                        if (in_node.last_node)
                        begin
                            head_reg <= '0;
                            tail_reg <= '0;
                            used_reg <= '0;
                            k_reg    <= '0;
                            if (start_ok)
                            begin
                                count_reg <= count_new;
                                cur_reg   <= IDX_W'(start_reg);
                                state_reg <= S_VISIT;
                            end
                            else
                            begin
                                count_reg <= '0;
                            end
                        end
                        else
                        begin
                            count_reg <= count_new;
                        end
                    end
                end
                S_POP:
                begin
                    head_reg  <= (head_reg == IDX_W'(MAX_NODES - 1)) ? '0 : head_reg + 1'b1;
                    used_reg  <= used_reg - 1'b1;
                    state_reg <= S_POPW;
                end
                S_POPW:
                begin
                    cur_reg   <= fifo_q;
                    state_reg <= S_VISIT;
                end
                S_VISIT:
                begin
                    scan_reg  <= CNT_W'(cur_reg) + 1'b1;
                    pend_reg  <= 1'b0;
                    state_reg <= S_SCAN;
                end
                S_SCAN:
                begin
                    pend_reg     <= scan_issue;
                    pend_idx_reg <= scan_reg[IDX_W-1:0];
                    if (scan_issue)
                    begin
                        scan_reg <= scan_reg + 1'b1;
                    end
                    if (push)
                    begin
                        tail_reg <= (tail_reg == IDX_W'(MAX_NODES - 1)) ? '0
                                    : tail_reg + 1'b1;
                        used_reg <= used_reg + 1'b1;
                    end
                    if (!scan_issue && !pend_reg)
                    begin
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT:
                begin
                    if (emit_go)
                    begin
                        out_label_reg <= label_q;
                        out_last_reg  <= emit_last;
                        k_reg         <= k_reg + 1'b1;
                        if (emit_last)
                        begin
                            count_reg <= '0;
                            head_reg  <= '0;
                            tail_reg  <= '0;
                            used_reg  <= '0;
                            state_reg <= S_LOAD;
                        end
                        else
                        begin
                            state_reg <= S_POP;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_LOAD;
                end
            endcase
        end
    end

    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= CNT_W'(MAX_NODES))
        else $error("visit queue occupancy beyond depth");

    a_walk_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_go && emit_last) |=> (count_reg == '0 && used_reg == '0))
        else $error("tree not cleared after final label");

    a_child_above: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && pend_reg) |-> (pend_idx_reg > cur_reg))
        else $error("child candidate not above current node");

    a_no_load_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (in_go && in_node.last_node && start_ok) |=> !in_node.ready)
        else $error("load channel open during walk");

endmodule
// ----------------------------------------------------------------------------

// ===== verif/level_order_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// level_order_checker
// Watches the node and visit channels and the start register port. Keeps a
// copy of the loaded tree, works out the breadth-first label sequence when
// the last node is taken, and compares each visit word against it.
// ----------------------------------------------------------------------------
module level_order_checker
    import patlo_pkg::*;
#(
    parameter int MAX_NODES = DEF_MAX_NODES
)(
    input  logic               clk,
    input  logic               rst_n,
    patlo_node_if              node_mon,
    patlo_visit_if             visit_mon,
    input  logic               cfg_we,
    input  logic [START_W-1:0] cfg_wdata,
    output int                 mismatches,
    output int                 pending_words
);

    typedef struct packed {
        logic [LABEL_W-1:0] visit_label;
        logic               last_visit;
    } visit_word_t;

    logic [PARENT_W-1:0] parent_mem [MAX_NODES];
    logic [LABEL_W-1:0]  label_mem  [MAX_NODES];
    int                  loaded;
    logic [START_W-1:0]  start_reg;
    visit_word_t         expected_visits [$];
    visit_word_t         want_word;
    int                  errors = 0;

    assign mismatches = errors;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        errors++;
    endtask

    // breadth-first walk over the nodes of the current load
    task automatic predict_walk();
        int          frontier [$];
        visit_word_t walk_words [$];
        visit_word_t w;
        int          cur;

        if (int'(start_reg) < loaded)
            frontier.push_back(int'(start_reg));
        while (frontier.size() > 0 && walk_words.size() < RESULT_CAP) begin
            cur           = frontier.pop_front();
            w.visit_label = label_mem[cur];
            w.last_visit  = 1'b0;
            walk_words.push_back(w);
            for (int i = cur + 1; i < loaded; i++)
                if (int'(parent_mem[i]) == cur)
                    frontier.push_back(i);
        end
        if (walk_words.size() > 0)
            walk_words[walk_words.size() - 1].last_visit = 1'b1;
        foreach (walk_words[k])
            expected_visits.push_back(walk_words[k]);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loaded    = 0;
            start_reg = '0;
            expected_visits.delete();
            pending_words = 0;
        end
        else
        begin
            if (cfg_we)
                start_reg = cfg_wdata;
            if (node_mon.valid && node_mon.ready)
            begin
                if (loaded < MAX_NODES)
                begin
                    parent_mem[loaded] = (loaded == 0) ? '0 : node_mon.parent_index;
                    label_mem[loaded]  = node_mon.node_label;
                    loaded++;
                end
                if (node_mon.last_node)
                begin
                    predict_walk();
                    loaded = 0;
                end
            end
            if (visit_mon.valid && visit_mon.ready)
            begin
                if (expected_visits.size() == 0)
                    report_mismatch($sformatf("unexpected visit word label %02h last %0b",
                                              visit_mon.visit_label, visit_mon.last_visit));
                else
                begin
                    want_word = expected_visits.pop_front();
                    if (visit_mon.visit_label !== want_word.visit_label)
                        report_mismatch($sformatf("visit_label got %02h want %02h",
                                                  visit_mon.visit_label,
                                                  want_word.visit_label));
                    if (visit_mon.last_visit !== want_word.last_visit)
                        report_mismatch($sformatf("last_visit got %0b want %0b (label %02h)",
                                                  visit_mon.last_visit,
                                                  want_word.last_visit,
                                                  want_word.visit_label));
                end
            end
            pending_words = expected_visits.size();
        end
    end

endmodule
// ----------------------------------------------------------------------------

// ===== verif/parent_array_tree_level_order_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// parent_array_tree_level_order_top_tb
// Loads trees of many shapes and sizes (chains, stars, binary, random, with
// orphans and overflow nodes) under several start node settings, with random
// gaps and stalls on both channels, and lets the checker judge the walks.
// ----------------------------------------------------------------------------
module parent_array_tree_level_order_top_tb;
    import patlo_pkg::*;

    localparam int TARGET_NODES  = 460;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 64;
    localparam int HOLD_CYCLES   = 600;

    typedef enum int {
        SHAPE_RANDOM,
        SHAPE_CHAIN,
        SHAPE_STAR,
        SHAPE_BINARY,
        SHAPE_NOISY
    } tree_shape_t;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               cfg_we    = 1'b0;
    logic [START_W-1:0] cfg_wdata = '0;
    int                 mismatches;
    int                 pending_words;
    int                 cycle_count   = 0;
    int                 nodes_sent    = 0;
    bit                 quiet         = 1'b0;
    bit                 hold_request  = 1'b0;

    patlo_node_if  node_ch ();
    patlo_visit_if visit_ch ();

    parent_array_tree_level_order_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_node   (node_ch),
        .out_visit (visit_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    level_order_checker #(
        .MAX_NODES (DEF_MAX_NODES)
    ) walk_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .node_mon      (node_ch),
        .visit_mon     (visit_ch),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .mismatches    (mismatches),
        .pending_words (pending_words)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic send_node(input logic [PARENT_W-1:0] parent,
                             input logic [LABEL_W-1:0] label, input bit last);
        int gap;

        gap = quiet ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            node_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        node_ch.parent_index = parent;
        node_ch.node_label   = label;
        node_ch.last_node    = last;
        node_ch.valid        = 1'b1;
        do @(posedge clk); while (!node_ch.ready);
        @(negedge clk);
        nodes_sent++;
    endtask

    task automatic wait_idle();
        node_ch.valid = 1'b0;
        wait (pending_words == 0);
        @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_start(input logic [START_W-1:0] value);
        wait_idle();
        cfg_we    = 1'b1;
        cfg_wdata = value;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    task automatic send_tree(input int n, input tree_shape_t shape);
        int parent;

        for (int i = 0; i < n; i++)
        begin
            if (i == 0)
                parent = $urandom_range(0, 31);
            else
                case (shape)
                    SHAPE_CHAIN:  parent = i - 1;
                    SHAPE_STAR:   parent = 0;
                    SHAPE_BINARY: parent = (i - 1) / 2;
                    SHAPE_NOISY:  parent = $urandom_range(0, 31);
                    default:      parent = $urandom_range(0, (i - 1 > 31) ? 31 : i - 1);
                endcase
            send_node(parent[PARENT_W-1:0], LABEL_W'($urandom_range(0, 255)), i == n - 1);
        end
    endtask

    // visit side: random stall per word, one long hold on request
    initial
    begin
        int stall;

        visit_ch.ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (hold_request)
            begin
                visit_ch.ready = 1'b0;
                hold_request   = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            stall = quiet ? 0 : $urandom_range(0, 10);
            if (stall > 0)
            begin
                visit_ch.ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            visit_ch.ready = 1'b1;
            do @(posedge clk); while (!visit_ch.valid);
            @(negedge clk);
        end
    end

    initial
    begin
        int          tree_no;
        int          pick;
        int          n;
        tree_shape_t shape;

        node_ch.valid        = 1'b0;
        node_ch.parent_index = '0;
        node_ch.node_label   = '0;
        node_ch.last_node    = 1'b0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // single node tree, start at reset value
        send_node(5'd0, 8'hFF, 1'b1);
        // root parent field ignored, orphan node skipped
        send_node(5'd31, 8'h00, 1'b0);
        send_node(5'd0, 8'hFF, 1'b0);
        send_node(5'd31, 8'h5A, 1'b0);
        send_node(5'd1, 8'h81, 1'b1);
        // start past node count: no words
        write_start(5'd31);
        send_node(5'd0, 8'h11, 1'b0);
        send_node(5'd0, 8'h22, 1'b0);
        send_node(5'd1, 8'h33, 1'b1);
        // walk from an inner node
        write_start(5'd2);
        send_node(5'd0, 8'hA0, 1'b0);
        send_node(5'd0, 8'hA1, 1'b0);
        send_node(5'd0, 8'hA2, 1'b0);
        send_node(5'd2, 8'hA3, 1'b0);
        send_node(5'd2, 8'hA4, 1'b1);
        write_start(5'd0);

        tree_no = 0;
        while (nodes_sent < TARGET_NODES)
        begin
            if (tree_no % 6 == 5)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 60)
                    write_start(5'd0);
                else if (pick < 85)
                    write_start(START_W'($urandom_range(0, 7)));
                else if (pick < 93)
                    write_start(5'd31);
                else
                    write_start(START_W'($urandom_range(0, 31)));
            end
            quiet = (tree_no % 9 == 4);
            if (tree_no == 12)
                hold_request = 1'b1;
            if (tree_no == 20)
                wait_idle();

            pick = $urandom_range(0, 99);
            if (pick < 75)
                n = $urandom_range(1, 10);
            else if (pick < 95)
                n = $urandom_range(11, 32);
            else
                n = $urandom_range(33, 36);

            pick = $urandom_range(0, 99);
            if (pick < 40)
                shape = SHAPE_RANDOM;
            else if (pick < 50)
                shape = SHAPE_CHAIN;
            else if (pick < 60)
                shape = SHAPE_STAR;
            else if (pick < 70)
                shape = SHAPE_BINARY;
            else
                shape = SHAPE_NOISY;

            send_tree(n, shape);
            tree_no++;
        end
        quiet = 1'b0;

        wait_idle();
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
// ----------------------------------------------------------------------------
